### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the add/sub/div/rem unit; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SASDM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SASDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/sasdm_pkg.sv
// Types and constants of the signed add/sub/div/rem unit.
package sasdm_pkg;

  // Operand and result width; the packed beat types below are built on it.
  localparam int DATA_WIDTH = 32;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM = 3'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MOD_ZERO = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic signed [DATA_WIDTH-1:0] first_operand;
    logic signed [DATA_WIDTH-1:0] second_operand;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result;
    logic [STATUS_W-1:0]          status;
  } out_t;

  // Work carried down the pipeline with each item.
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [STATUS_W-1:0]   status;
    logic                  neg_res;
    logic [DATA_WIDTH-1:0] sum;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] dvs;
  } stage_t;

endpackage

### hw/rtl/signed_add_sub_div_mod_unit.sv
// Top level of the pipelined signed add/subtract/divide/remainder unit.
//
// Takes one operation per clock while in_stall is low and returns one result beat per operation, in order.
// Every item, add and subtract included, runs the same pipeline: an entry register,
// DATA_WIDTH division stages that each settle one quotient bit (32 for the default
// width), and the output register, in that order. Sustained rate is one item per
// cycle while out_stall stays low. A skid register behind the
// output holds one result when the consumer stalls; while it is full the pipeline
// freezes and in_stall is high. in_stall comes straight from a flop. Division
// truncates toward zero, the remainder takes the dividend's sign, a zero divisor
// returns 0 with status 1 (divide) or 2 (remainder), and unknown codes return 0.
`include "assert_macros.svh"

module signed_add_sub_div_mod_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sasdm_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sasdm_pkg::out_t  out_data
);

  localparam int W = sasdm_pkg::DATA_WIDTH;

  logic                  adv;
  logic [W:0]            vld;
  sasdm_pkg::stage_t     stg [0:W];
  sasdm_pkg::out_t       last_res;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  sasdm_pkg::out_t       out_data_r;
  sasdm_pkg::out_t       out_data_nxt;
  logic                  skid_valid_r;
  logic                  skid_valid_nxt;
  sasdm_pkg::out_t       skid_data_r;
  sasdm_pkg::out_t       skid_data_nxt;

  // The whole pipeline moves together unless the skid register is holding a beat.
  assign adv      = ~skid_valid_r;
  assign in_stall = skid_valid_r;

  // Entry stage.
  sasdm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .vld_o    (vld[0]),
    .stg_o    (stg[0])
  );

  // Division stages, one quotient bit each.
  for (genvar k = 0; k < W; k++) begin : g_div
    sasdm_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld[k]),
      .stg_i (stg[k]),
      .vld_o (vld[k+1]),
      .stg_o (stg[k+1])
    );
  end

  // Final selection and sign.
  sasdm_back u_back (
    .stg_i (stg[W]),
    .res_o (last_res)
  );

  // Output register with a one-beat skid behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    priority if (skid_valid_r) begin
      if (!out_stall) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (vld[W]) begin
      if (!out_valid_r || !out_stall) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = last_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = last_res;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A held skid beat always sits behind a valid output beat.
  `SASDM_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  // An error status always carries a zero result.
  `SASDM_ASSERT_SAME(a_err_zero, out_valid_r && |out_data_r.status, out_data_r.result == '0)
  // The skid drains as soon as the consumer takes the output beat.
  `SASDM_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r)
  // A frozen pipeline keeps every valid bit in place.
  `SASDM_ASSERT_NEXT(a_freeze_holds, !adv, $stable(vld))

endmodule

### hw/rtl/sasdm_front.sv
// Entry stage: add/subtract, operand magnitudes, result sign and zero-divisor status.
module sasdm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  sasdm_pkg::in_t    in_data,
  output logic              vld_o,
  output sasdm_pkg::stage_t stg_o
);

  localparam int W = sasdm_pkg::DATA_WIDTH;

  logic              vld_r;
  sasdm_pkg::stage_t stg_r;
  sasdm_pkg::stage_t stg_nxt;
  logic [W-1:0]      a;
  logic [W-1:0]      b;
  logic              a_neg;
  logic              b_neg;

  assign a     = in_data.first_operand;
  assign b     = in_data.second_operand;
  assign a_neg = a[W-1];
  assign b_neg = b[W-1];

  // Prepare the item: wrapped sum, magnitudes for the divider and the sign of the answer.
  always_comb begin
    stg_nxt.kind    = in_data.kind;
    stg_nxt.status  = sasdm_pkg::ST_OK;
    stg_nxt.neg_res = 1'b0;
    stg_nxt.sum     = '0;
    stg_nxt.rem     = '0;
    stg_nxt.quo     = a_neg ? (~a + 1'b1) : a;
    stg_nxt.dvs     = b_neg ? (~b + 1'b1) : b;
    unique case (in_data.kind)
      sasdm_pkg::KIND_ADD: begin
        stg_nxt.sum = a + b;
      end
      sasdm_pkg::KIND_SUB: begin
        stg_nxt.sum = a - b;
      end
      sasdm_pkg::KIND_DIV: begin
        stg_nxt.neg_res = a_neg ^ b_neg;
        if (b == '0) begin
          stg_nxt.status = sasdm_pkg::ST_DIV_ZERO;
        end
      end
      sasdm_pkg::KIND_REM: begin
        stg_nxt.neg_res = a_neg;
        if (b == '0) begin
          stg_nxt.status = sasdm_pkg::ST_MOD_ZERO;
        end
      end
      default: begin
        stg_nxt.sum = '0;
      end
    endcase
  end

  // Valid travels with the data and moves only when the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

### hw/rtl/sasdm_div_stage.sv
// One restoring division step: develops one quotient bit per stage.
module sasdm_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  sasdm_pkg::stage_t stg_i,
  output logic              vld_o,
  output sasdm_pkg::stage_t stg_o
);

  localparam int W = sasdm_pkg::DATA_WIDTH;

  logic              vld_r;
  sasdm_pkg::stage_t stg_r;
  sasdm_pkg::stage_t stg_nxt;
  logic [W:0]        shifted;
  logic [W+1:0]      diff;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try the divisor.
  assign shifted = {stg_i.rem, stg_i.quo[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, stg_i.dvs};
  assign fits    = ~diff[W+1];

  always_comb begin
    stg_nxt     = stg_i;
    stg_nxt.rem = fits ? diff[W-1:0] : shifted[W-1:0];
    stg_nxt.quo = {stg_i.quo[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

### hw/rtl/sasdm_back.sv
// Result selection: picks sum, quotient or remainder and applies the sign.
module sasdm_back (
  input  sasdm_pkg::stage_t stg_i,
  output sasdm_pkg::out_t   res_o
);

  localparam int W = sasdm_pkg::DATA_WIDTH;

  logic [W-1:0] mag;
  logic [W-1:0] signed_mag;

  // Quotient for divide, remainder for remainder; negate when the sign calls for it.
  assign mag        = (stg_i.kind == sasdm_pkg::KIND_REM) ? stg_i.rem : stg_i.quo;
  assign signed_mag = stg_i.neg_res ? (~mag + 1'b1) : mag;

  always_comb begin
    res_o.status = stg_i.status;
    res_o.result = '0;
    priority if (stg_i.status != sasdm_pkg::ST_OK) begin
      res_o.result = '0;
    end else if (stg_i.kind == sasdm_pkg::KIND_ADD || stg_i.kind == sasdm_pkg::KIND_SUB) begin
      res_o.result = stg_i.sum;
    end else if (stg_i.kind == sasdm_pkg::KIND_DIV || stg_i.kind == sasdm_pkg::KIND_REM) begin
      res_o.result = signed_mag;
    end else begin
      res_o.result = '0;
    end
  end

endmodule
